FILE: sv/assert_macros.svh
// Assertion macros used by the sequencer RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, masked while reset is asserted.
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: sv/dsc_pkg.sv
// Package: constants shared by the substring counter files.
`default_nettype none
package dsc_pkg;
  localparam int MAX_LEN_DEF  = 256;
  localparam int ALPHABET_DEF = 256;
  localparam int CHAR_W       = 8;
  localparam int COUNT_W      = 16;
endpackage
`default_nettype wire

FILE: sv/dsc_if.sv
// Interfaces: input byte channel and result channel.
`default_nettype none
interface dsc_in_if;
  import dsc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              last_char;
  modport source (output valid, output char_in, output last_char, input ready);
  modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface dsc_out_if;
  import dsc_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] substring_count;
  logic               too_long;
  modport source (output valid, output substring_count, output too_long, input ready);
  modport sink   (input valid, input substring_count, input too_long, output ready);
endinterface
`default_nettype wire

FILE: sv/dsc_text_mem.sv
// Text memory: one write port, two registered read ports.
`default_nettype none
module dsc_text_mem #(
  parameter int MAX_LEN = dsc_pkg::MAX_LEN_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(MAX_LEN)-1:0]   wr_addr,
  input  wire logic [dsc_pkg::CHAR_W-1:0]   wr_data,
  input  wire logic [$clog2(MAX_LEN)-1:0]   rd_addr_a,
  input  wire logic [$clog2(MAX_LEN)-1:0]   rd_addr_b,
  output logic      [dsc_pkg::CHAR_W-1:0]   rd_data_a,
  output logic      [dsc_pkg::CHAR_W-1:0]   rd_data_b
);
  import dsc_pkg::*;

  logic [CHAR_W-1:0] mem [MAX_LEN];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end
endmodule
`default_nettype wire

FILE: sv/dsc_seq.sv
// Sequencer: load, diagonal compare sweep, per-position max store, final sum.
`default_nettype none
`include "assert_macros.svh"
module dsc_seq #(
  parameter int MAX_LEN  = dsc_pkg::MAX_LEN_DEF,
  parameter int ALPHABET = dsc_pkg::ALPHABET_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [dsc_pkg::CHAR_W-1:0]   char_in,
  input  wire logic                         last_char,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [dsc_pkg::COUNT_W-1:0]  substring_count,
  output logic                              too_long,
  output logic                              mem_wr_en,
  output logic      [$clog2(MAX_LEN)-1:0]   mem_wr_addr,
  output logic      [dsc_pkg::CHAR_W-1:0]   mem_wr_data,
  output logic      [$clog2(MAX_LEN)-1:0]   mem_rd_addr_a,
  output logic      [$clog2(MAX_LEN)-1:0]   mem_rd_addr_b,
  input  wire logic [dsc_pkg::CHAR_W-1:0]   mem_rd_data_a,
  input  wire logic [dsc_pkg::CHAR_W-1:0]   mem_rd_data_b
);
  import dsc_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);

  typedef enum logic [2:0] {S_LOAD, S_RD, S_WR, S_SRD, S_SADD, S_OUT} state_t;

  state_t             state_r;
  logic [LW-1:0]      len_r;
  logic               ovf_r;
  logic [AW-1:0]      d_r;
  logic [AW-1:0]      i_r;
  logic [AW-1:0]      run_r;
  logic [COUNT_W-1:0] acc_r;
  logic               out_valid_r;
  logic [COUNT_W-1:0] count_r;
  logic               too_long_r;

  // longest match of position i with any later position
  logic [AW-1:0] maxl_mem [MAX_LEN];
  logic [AW-1:0] maxl_q;

  logic               accept;
  logic               fits;
  logic [LW-1:0]      len_nxt;
  logic               ovf_nxt;
  logic [CHAR_W-1:0]  char_sat;
  logic [AW-1:0]      run_nxt;
  logic [AW-1:0]      max_nxt;
  logic [COUNT_W-1:0] acc_nxt;

  assign in_ready = (state_r == S_LOAD);
  assign accept   = in_valid && in_ready;
  assign fits     = (len_r < LW'(MAX_LEN));
  assign len_nxt  = fits ? len_r + LW'(1) : len_r;
  assign ovf_nxt  = ovf_r || !fits;
  assign char_sat = ({1'b0, char_in} >= (CHAR_W+1)'(ALPHABET)) ?
                    CHAR_W'(ALPHABET - 1) : char_in;

  assign mem_wr_en     = accept && fits;
  assign mem_wr_addr   = len_r[AW-1:0];
  assign mem_wr_data   = char_sat;
  assign mem_rd_addr_a = i_r;
  assign mem_rd_addr_b = i_r + d_r;

  assign run_nxt = (mem_rd_data_a == mem_rd_data_b) ? run_r + AW'(1) : '0;
  assign max_nxt = (d_r == AW'(1) || run_nxt > maxl_q) ? run_nxt : maxl_q;
  assign acc_nxt = acc_r + COUNT_W'(len_r - LW'(i_r)) - COUNT_W'(maxl_q);

  assign out_valid       = out_valid_r;
  assign substring_count = count_r;
  assign too_long        = too_long_r;

  always_ff @(posedge clk) begin
    if (state_r == S_WR) begin
      maxl_mem[i_r] <= max_nxt;
    end
    maxl_q <= maxl_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      d_r         <= '0;
      i_r         <= '0;
      run_r       <= '0;
      acc_r       <= '0;
      count_r     <= '0;
      too_long_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (accept) begin
            len_r <= len_nxt;
            ovf_r <= ovf_nxt;
            if (last_char) begin
              if (ovf_nxt) begin
                count_r     <= '0;
                too_long_r  <= 1'b1;
                out_valid_r <= 1'b1;
                state_r     <= S_OUT;
              end else if (len_nxt == LW'(1)) begin
                count_r     <= COUNT_W'(1);
                too_long_r  <= 1'b0;
                out_valid_r <= 1'b1;
                state_r     <= S_OUT;
              end else begin
                d_r     <= AW'(1);
                i_r     <= AW'(len_nxt - LW'(2));
                run_r   <= '0;
                acc_r   <= COUNT_W'(1);
                state_r <= S_RD;
              end
            end
          end
        end
        S_RD: state_r <= S_WR;
        S_WR: begin
          if (i_r == '0) begin
            run_r <= '0;
            if (d_r == AW'(len_r - LW'(1))) begin
              state_r <= S_SRD;
            end else begin
              d_r     <= d_r + AW'(1);
              i_r     <= AW'(len_r - LW'(2) - LW'(d_r));
              state_r <= S_RD;
            end
          end else begin
            i_r     <= i_r - AW'(1);
            run_r   <= run_nxt;
            state_r <= S_RD;
          end
        end
        S_SRD: state_r <= S_SADD;
        S_SADD: begin
          acc_r <= acc_nxt;
          if (i_r == AW'(len_r - LW'(2))) begin
            count_r     <= acc_nxt;
            too_long_r  <= 1'b0;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end else begin
            i_r     <= i_r + AW'(1);
            state_r <= S_SRD;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            len_r       <= '0;
            ovf_r       <= 1'b0;
            state_r     <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  `ASSERT_PROP(a_no_load_while_out, out_valid_r |-> !in_ready)
  `ASSERT_PROP(a_diag_in_range, (state_r == S_WR) |-> (LW'(d_r) < len_r))
  `ASSERT_PROP(a_overflow_zero, (out_valid_r && too_long_r) |-> (count_r == '0))
  `ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (in_ready && !out_valid_r))
endmodule
`default_nettype wire

FILE: sv/distinct_substring_counter_top.sv
// Top level: distinct substring counter with byte input and count output.
// Bytes of a string arrive one word at a time; the word flagged last_char
// closes the string and triggers one result word carrying the number of
// distinct nonempty substrings (low 16 bits) and the too_long flag. Strings
// longer than MAX_LEN keep their first MAX_LEN bytes, drop the rest and report
// count 0 with too_long set. Bytes at or above ALPHABET saturate to ALPHABET-1.
// Loading accepts one byte per cycle. For a string of n bytes the compute phase
// walks every diagonal of the pair table, one pair at a time (read, then
// update) through the two read ports of the text memory, then sums the
// per-position match maxima; a single-byte or too-long string skips compute.
// The result then waits in an output register until taken. Input is ready
// again the cycle after the result word moves. No input word is taken during
// compute or while a result is pending. No clearing pass after reset is needed.
`default_nettype none
module distinct_substring_counter_top #(
  parameter int MAX_LEN  = dsc_pkg::MAX_LEN_DEF,
  parameter int ALPHABET = dsc_pkg::ALPHABET_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  dsc_in_if.sink   in_ch,
  dsc_out_if.source out_ch
);
  import dsc_pkg::*;

  localparam int AW = $clog2(MAX_LEN);

  // text memory hookup
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [CHAR_W-1:0] mem_wr_data;
  logic [AW-1:0]     mem_rd_addr_a;
  logic [AW-1:0]     mem_rd_addr_b;
  logic [CHAR_W-1:0] mem_rd_data_a;
  logic [CHAR_W-1:0] mem_rd_data_b;

  // sequencer: load, compare sweep, sum, result register
  dsc_seq #(
    .MAX_LEN  (MAX_LEN),
    .ALPHABET (ALPHABET)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .char_in         (in_ch.char_in),
    .last_char       (in_ch.last_char),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .substring_count (out_ch.substring_count),
    .too_long        (out_ch.too_long),
    .mem_wr_en       (mem_wr_en),
    .mem_wr_addr     (mem_wr_addr),
    .mem_wr_data     (mem_wr_data),
    .mem_rd_addr_a   (mem_rd_addr_a),
    .mem_rd_addr_b   (mem_rd_addr_b),
    .mem_rd_data_a   (mem_rd_data_a),
    .mem_rd_data_b   (mem_rd_data_b)
  );

  // string storage, two reads per cycle for the pair compare
  dsc_text_mem #(
    .MAX_LEN (MAX_LEN)
  ) u_text (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (mem_wr_data),
    .rd_addr_a (mem_rd_addr_a),
    .rd_addr_b (mem_rd_addr_b),
    .rd_data_a (mem_rd_data_a),
    .rd_data_b (mem_rd_data_b)
  );
endmodule
`default_nettype wire

FILE: test/tb_top.sv
// Testbench: random and directed strings checked against a brute-force substring count.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dsc_pkg::*;

  // Longest quiet stretch: a full-length string has the longest compute
  // phase, so allow a wide margin.
  localparam int QUIET_LIMIT  = 300000;
  localparam int TARGET_ITEMS = 1550;
  localparam int CALM_ITEMS   = 150;
  localparam int SETTLE       = 40;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               too_long;
  } count_word_t;

  logic clk;
  logic rst_n;

  dsc_in_if  in_ch ();
  dsc_out_if out_ch ();

  distinct_substring_counter_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow of the string being loaded and the queue of counts still owed.
  logic [CHAR_W-1:0] shadow_text [MAX_LEN_DEF];
  int                shadow_len;
  bit                shadow_ovf;
  count_word_t       pending_counts [$];

  int  errors;
  int  words_sent;
  int  strings_done;
  int  overflow_strings;
  int  counts_checked;
  int  quiet_cycles;
  bit  calm;
  int  stall_left;

  // Count distinct substrings directly: a substring is counted at its
  // rightmost start, i.e. prefixes of suffix i longer than its best match
  // with any later suffix.
  function automatic logic [COUNT_W-1:0] brute_distinct(int n);
    int unsigned total;
    int best;
    int k;
    total = 0;
    for (int i = 0; i < n; i++) begin
      best = 0;
      for (int j = i + 1; j < n; j++) begin
        k = 0;
        while (j + k < n && shadow_text[i + k] == shadow_text[j + k]) k++;
        if (k > best) best = k;
      end
      total += n - i - best;
    end
    return total[COUNT_W-1:0];
  endfunction

  // Update the shadow string with one accepted byte; queue a count on last.
  function automatic void absorb_byte(logic [CHAR_W-1:0] c, bit last);
    count_word_t w;
    logic [CHAR_W-1:0] sym;
    sym = (c >= ALPHABET_DEF) ? CHAR_W'(ALPHABET_DEF - 1) : c;
    if (shadow_len < MAX_LEN_DEF) begin
      shadow_text[shadow_len] = sym;
      shadow_len++;
    end else begin
      shadow_ovf = 1'b1;
    end
    if (last) begin
      w.too_long = shadow_ovf;
      w.count    = shadow_ovf ? '0 : brute_distinct(shadow_len);
      pending_counts.push_back(w);
      strings_done++;
      if (shadow_ovf) overflow_strings++;
      shadow_len = 0;
      shadow_ovf = 1'b0;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Send one byte word; called and returning at a falling edge.
  task automatic send_byte(logic [CHAR_W-1:0] c, bit last);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_in   <= c;
    in_ch.last_char <= last;
    do @(posedge clk); while (!in_ch.ready);
    absorb_byte(c, last);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_string(logic [CHAR_W-1:0] s [$]);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  // Hold the input idle until every owed count has come back.
  task automatic drain_counts();
    in_ch.valid <= 1'b0;
    while (pending_counts.size() != 0) @(negedge clk);
  endtask

  // Random byte: narrow alphabets give repeats, wide ones exercise all bits.
  function automatic logic [CHAR_W-1:0] pick_byte(int mode);
    case (mode)
      0: return CHAR_W'($urandom_range(0, 1));
      1: return CHAR_W'($urandom_range(97, 99));
      2: return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
      default: return CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_directed();
    send_string({8'h00});
    send_string({8'hFF});
    send_string({8'h00, 8'hFF});
    send_string({8'hFF, 8'h00});
    send_string({8'h41, 8'h41, 8'h41, 8'h41});
    send_string({8'h61, 8'h62, 8'h61, 8'h62, 8'h61});
    send_string({8'h55, 8'hAA, 8'h55});
    send_string({8'h01, 8'h02, 8'h80, 8'h7F});
    drain_counts();
  endtask

  // Full-length strings and ones that run past the limit.
  task automatic test_long_strings();
    logic [CHAR_W-1:0] s [$];
    s = {};
    for (int i = 0; i < MAX_LEN_DEF; i++) s.push_back(8'h5A);
    send_string(s);
    s = {};
    for (int i = 0; i < MAX_LEN_DEF; i++) s.push_back(pick_byte(0));
    send_string(s);
    s = {};
    for (int i = 0; i < MAX_LEN_DEF + 1; i++) s.push_back(pick_byte(3));
    send_string(s);
    s = {};
    for (int i = 0; i < MAX_LEN_DEF + 20; i++) s.push_back(pick_byte(1));
    send_string(s);
    drain_counts();
  endtask

  task automatic test_random_strings(int stop_at);
    logic [CHAR_W-1:0] s [$];
    int len;
    int mode;
    while (words_sent < stop_at) begin
      s = {};
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      mode = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) s.push_back(pick_byte(mode));
      send_string(s);
    end
  endtask

  // Result side: random ready stalls, calm near the end.
  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Check each accepted count word against the oldest owed one.
  always @(posedge clk) begin
    count_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_counts.size() == 0) begin
        report_mismatch("unexpected count word", out_ch.substring_count, -1);
      end else begin
        want = pending_counts.pop_front();
        counts_checked++;
        if (out_ch.substring_count !== want.count)
          report_mismatch("substring_count", out_ch.substring_count, want.count);
        if (out_ch.too_long !== want.too_long)
          report_mismatch("too_long", out_ch.too_long, want.too_long);
      end
    end
  end

  // Watchdog: cycles with no word moving on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.char_in   = '0;
    in_ch.last_char = 1'b0;
    out_ch.ready    = 1'b1;
    quiet_cycles    = 0;
    stall_left      = 0;
    calm            = 1'b0;
    errors          = 0;
    words_sent      = 0;
    strings_done    = 0;
    overflow_strings = 0;
    counts_checked  = 0;
    shadow_len      = 0;
    shadow_ovf      = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_long_strings();
    test_random_strings(TARGET_ITEMS - CALM_ITEMS);
    drain_counts();
    calm = 1'b1;
    test_random_strings(TARGET_ITEMS);

    in_ch.valid <= 1'b0;
    while (pending_counts.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("covered %0d byte words in %0d strings (%0d over length), %0d counts checked",
             words_sent, strings_done, overflow_strings, counts_checked);
    $display("directed edge bytes, full-length and overflow strings, random stalls both sides");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+sv
sv/dsc_pkg.sv
sv/dsc_if.sv
sv/dsc_text_mem.sv
sv/dsc_seq.sv
sv/distinct_substring_counter_top.sv
test/tb_top.sv
